// File: rtl/nsf_pkg.sv
// shared types and constants for the non-overlapping substring finder
package nsf_pkg;

  localparam int          DEF_MAX_PATTERN = 16;
  localparam longint unsigned DEF_MAX_TEXT = 64'd65536;

  localparam int LEN_W   = 5;   // pattern_length register width
  localparam int PAT_MAX = 16;  // pattern bytes held by the two pattern registers
  localparam int START_W = 16;  // match_start field width
  localparam int BLK_W   = 4;   // blocked byte counter width
  localparam int Q_DEPTH = 4;   // entries between front and back
  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 5;

  typedef enum logic [1:0] {
    REG_LENGTH   = 2'd0,
    REG_PAT_LOW  = 2'd1,
    REG_PAT_HIGH = 2'd2,
    REG_NONE     = 2'd3
  } nsf_reg_t;

  typedef struct packed {
    logic found;
    logic last;
  } nsf_flags_t;

endpackage

// File: rtl/nsf_front.sv
// front end: byte window, parallel pattern compare, index and block counters
module nsf_front import nsf_pkg::*; #(
  parameter int              MAX_PATTERN = DEF_MAX_PATTERN,
  parameter longint unsigned MAX_TEXT    = DEF_MAX_TEXT,
  localparam int             IDX_W       = $clog2(MAX_TEXT)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic                     q_full,
  input  logic [7:0]               text_byte,
  input  logic                     last_byte,
  input  logic [LEN_W-1:0]         cfg_len,
  input  logic [8*PAT_MAX-1:0]     pattern,
  output logic                     q_push,
  output nsf_flags_t               q_flags,
  output logic [IDX_W-1:0]         q_cur,
  output logic [LEN_W-1:0]         q_len
);

  localparam int WIN = (MAX_PATTERN < PAT_MAX) ? MAX_PATTERN : PAT_MAX;
  localparam int CW  = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;

  logic [7:0]       win_r   [WIN];
  logic [7:0]       win_n   [WIN];
  logic [7:0]       win_nxt [WIN];
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic [LEN_W-1:0] eff_len;
  logic [WIN-1:0]   ok;
  logic             accept, len_reached, found;

  assign accept = push & ~q_full;

  always_comb begin
    if (cfg_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (cfg_len > LEN_W'(WIN)) begin
      eff_len = LEN_W'(WIN);
    end else begin
      eff_len = cfg_len;
    end
  end

  // window after taking the new byte, newest at entry 0
  always_comb begin
    win_n[0] = text_byte;
    for (int k = 1; k < WIN; k++) begin
      win_n[k] = win_r[k-1];
    end
  end

  // pattern byte i lines up with the byte eff_len-1-i places back
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      ok[i] = 1'b1;
      for (int j = 0; j < WIN; j++) begin
        if (LEN_W'(i + j + 1) == eff_len) begin
          ok[i] = (pattern[8*i +: 8] == win_n[j]);
        end
      end
    end
  end

  assign len_reached = (CW'(idx_r) + CW'(1)) >= CW'(eff_len);
  assign found       = (blk_r == '0) && len_reached && (&ok);

  always_comb begin
    blk_nxt = blk_r;
    idx_nxt = idx_r;
    for (int k = 0; k < WIN; k++) begin
      win_nxt[k] = win_n[k];
    end
    if (blk_r != '0) begin
      blk_nxt = blk_r - BLK_W'(1);
    end else if (found) begin
      blk_nxt = BLK_W'(eff_len - LEN_W'(1));
    end
    if (idx_r < IDX_W'(MAX_TEXT - 1)) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    if (last_byte) begin
      blk_nxt = '0;
      idx_nxt = '0;
      for (int k = 0; k < WIN; k++) begin
        win_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      blk_r <= '0;
      for (int k = 0; k < WIN; k++) begin
        win_r[k] <= '0;
      end
    end else if (accept) begin
      idx_r <= idx_nxt;
      blk_r <= blk_nxt;
      for (int k = 0; k < WIN; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

  assign q_push        = accept & (found | last_byte);
  assign q_flags.found = found;
  assign q_flags.last  = last_byte;
  assign q_cur         = idx_r;
  assign q_len         = eff_len;

endmodule

// File: rtl/nsf_queue.sv
// small fifo between front and back
module nsf_queue import nsf_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = Q_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr_en & ~full;
  assign do_rd = rd_en & ~empty;

  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// File: rtl/nsf_back.sv
// back end: forms the start index and holds the result register
module nsf_back import nsf_pkg::*; #(
  parameter int IDX_W = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  nsf_flags_t         q_flags,
  input  logic [IDX_W-1:0]   q_cur,
  input  logic [LEN_W-1:0]   q_len,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic               out_match_found,
  output logic [START_W-1:0] out_match_start,
  output logic               out_text_done
);

  localparam int CW = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;
  localparam int SW = (CW > START_W) ? CW : START_W;

  logic               valid_r, valid_nxt;
  logic               found_r;
  logic               done_r;
  logic [START_W-1:0] start_r;
  logic [SW-1:0]      start_full;
  logic [START_W-1:0] start_nxt;

  // start = cur + 1 - len, never negative on a match
  assign start_full = SW'(q_cur) + SW'(1) - SW'(q_len);
  assign start_nxt  = q_flags.found ? start_full[START_W-1:0] : '0;

  assign q_pop = ~q_empty & (~valid_r | pop);

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      found_r <= q_flags.found;
      done_r  <= q_flags.last;
      start_r <= start_nxt;
    end
  end

  assign empty           = ~valid_r;
  assign out_match_found = found_r;
  assign out_match_start = start_r;
  assign out_text_done   = done_r;

endmodule

// File: rtl/nonoverlapping_substring_finder.sv
// Streaming non-overlapping substring search. Takes one text byte per clock
// while full is low and yields a request for each match (start index of the
// occurrence) and for the last byte of each text. The whole pattern window is
// compared in parallel in the cycle a byte is accepted, so the sustained rate
// is one byte per cycle while the queue is not full; a result is written into
// the four-entry queue at the accepting edge and moves into the output
// register once that register is empty or being popped. full rises only when
// the queue is full because results are not being popped. No clearing pass
// after reset. Registers: pattern_length at 0x00, pattern_low at 0x08,
// pattern_high at 0x10, all 64-bit reads and writes.
module nonoverlapping_substring_finder import nsf_pkg::*; #(
  parameter int              MAX_PATTERN = DEF_MAX_PATTERN,
  parameter longint unsigned MAX_TEXT    = DEF_MAX_TEXT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_text_byte,
  input  logic               in_last_byte,
  output logic               empty,
  input  logic               pop,
  output logic               out_match_found,
  output logic [START_W-1:0] out_match_start,
  output logic               out_text_done,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int IDX_W = $clog2(MAX_TEXT);
  localparam int QW    = 2 + IDX_W + LEN_W;

  logic [LEN_W-1:0]  len_r;
  logic [DATA_W-1:0] pat_lo_r, pat_hi_r;
  nsf_reg_t          reg_sel;
  logic              wr_en;

  logic             q_push, q_pop, q_full, q_empty;
  nsf_flags_t       f_flags, b_flags;
  logic [IDX_W-1:0] f_cur, b_cur;
  logic [LEN_W-1:0] f_len, b_len;
  logic [QW-1:0]    q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign reg_sel = nsf_reg_t'(paddr[4:3]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= LEN_W'(1);
      pat_lo_r <= '0;
      pat_hi_r <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_LENGTH:   len_r    <= pwdata[LEN_W-1:0];
        REG_PAT_LOW:  pat_lo_r <= pwdata;
        REG_PAT_HIGH: pat_hi_r <= pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LENGTH:   prdata = DATA_W'(len_r);
      REG_PAT_LOW:  prdata = pat_lo_r;
      REG_PAT_HIGH: prdata = pat_hi_r;
      default:      prdata = '0;
    endcase
  end

  nsf_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_TEXT    (MAX_TEXT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .q_full    (q_full),
    .text_byte (in_text_byte),
    .last_byte (in_last_byte),
    .cfg_len   (len_r),
    .pattern   ({pat_hi_r, pat_lo_r}),
    .q_push    (q_push),
    .q_flags   (f_flags),
    .q_cur     (f_cur),
    .q_len     (f_len)
  );

  assign q_wdata = {f_flags, f_cur, f_len};
  assign full    = q_full;

  nsf_queue #(
    .W     (QW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty)
  );

  assign {b_flags, b_cur, b_len} = q_rdata;

  nsf_back #(
    .IDX_W (IDX_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_flags         (b_flags),
    .q_cur           (b_cur),
    .q_len           (b_len),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .out_match_found (out_match_found),
    .out_match_start (out_match_start),
    .out_text_done   (out_text_done)
  );

endmodule
